### hdl/fixed_point_alu_assert.svh
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

`define FPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define FPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/fpa_pkg.sv
package fpa_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned NumWidth = 32 + FracBits + 2;
  localparam int unsigned QuoWidth = 32 + FracBits + 1;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw = 2;

  typedef enum logic [3:0] {
    OpAdd = 4'd0, OpSub = 4'd1, OpMul = 4'd2, OpDiv = 4'd3, OpCmp = 4'd4,
    OpMax = 4'd5, OpMin = 4'd6, OpInc = 4'd7, OpDec = 4'd8, OpToInt = 4'd9
  } op_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] a_value;
    logic signed [31:0] b_value;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               greater;
    logic               less;
    logic               equal;
    logic               overflow;
    logic               divide_by_zero;
  } fpa_out_t;

  // Classified transaction handed from the front end to the back end.
  typedef struct packed {
    logic        is_div;
    logic        div_zero;
    logic        neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    fpa_out_t    quick;
  } fpa_job_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v, output logic ovf);
    logic [31:0] r;
    begin
      ovf = 1'b0;
      r = v[31:0];
      if (v > 34'sd2147483647) begin
        ovf = 1'b1; r = 32'h7fff_ffff;
      end else if (v < -34'sd2147483648) begin
        ovf = 1'b1; r = 32'h8000_0000;
      end
      return r;
    end
  endfunction

endpackage

### hdl/fpa_front.sv
module fpa_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  fpa_pkg::fpa_in_t in_i,
  output logic            valid_o,
  output fpa_pkg::fpa_job_t job_o
);
  import fpa_pkg::*;

  logic              valid_q;
  fpa_job_t          job_q, job_d;
  logic signed [63:0] prod_q, prod_d;
  logic              is_mul_q;

  always_comb begin
    logic signed [33:0] a, b;
    logic ovf;
    a = 34'(in_i.a_value);
    b = 34'(in_i.b_value);
    ovf = 1'b0;
    job_d = '0;
    job_d.neg = in_i.a_value[31] ^ in_i.b_value[31];
    job_d.mag_a = in_i.a_value[31] ? 32'(-a) : in_i.a_value;
    job_d.mag_b = in_i.b_value[31] ? 32'(-b) : in_i.b_value;
    prod_d = 64'(job_d.mag_a) * 64'(job_d.mag_b);
    unique case (in_i.kind)
      OpAdd: begin
        job_d.quick.result_value = sat32(a + b, ovf); job_d.quick.overflow = ovf;
      end
      OpSub: begin
        job_d.quick.result_value = sat32(a - b, ovf); job_d.quick.overflow = ovf;
      end
      OpMul: ;
      OpDiv: begin
        job_d.is_div = 1'b1;
        job_d.div_zero = (in_i.b_value == '0);
        job_d.quick.divide_by_zero = job_d.div_zero;
      end
      OpCmp: begin
        job_d.quick.greater = in_i.a_value > in_i.b_value;
        job_d.quick.less = in_i.a_value < in_i.b_value;
        job_d.quick.equal = in_i.a_value == in_i.b_value;
      end
      OpMax: job_d.quick.result_value =
               (in_i.a_value > in_i.b_value) ? in_i.a_value : in_i.b_value;
      OpMin: job_d.quick.result_value =
               (in_i.a_value < in_i.b_value) ? in_i.a_value : in_i.b_value;
      OpInc: begin
        job_d.quick.result_value = sat32(a + 34'sd1, ovf); job_d.quick.overflow = ovf;
      end
      OpDec: begin
        job_d.quick.result_value = sat32(a - 34'sd1, ovf); job_d.quick.overflow = ovf;
      end
      OpToInt: job_d.quick.result_value = in_i.a_value >>> FracBits;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      job_q <= job_d;
      prod_q <= prod_d;
      is_mul_q <= (in_i.kind == OpMul);
    end
  end

  // Round and saturate the registered product combinationally.
  always_comb begin
    logic [63:0] q;
    logic signed [65:0] s;
    logic ovf;
    job_o = job_q;
    q = (64'(prod_q) + (64'd1 << (FracBits - 1))) >> FracBits;
    s = job_q.neg ? -66'(q) : 66'(q);
    ovf = 1'b0;
    if (is_mul_q) begin
      if (s > 66'sd2147483647) begin
        ovf = 1'b1; job_o.quick.result_value = 32'h7fff_ffff;
      end else if (s < -66'sd2147483648) begin
        ovf = 1'b1; job_o.quick.result_value = 32'h8000_0000;
      end else begin
        job_o.quick.result_value = s[31:0];
      end
      job_o.quick.overflow = ovf;
    end
  end

  assign valid_o = valid_q;

endmodule

### hdl/fpa_queue.sv
module fpa_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fpa_pkg::fpa_job_t data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [fpa_pkg::FifoAw:0] count_o,
  output fpa_pkg::fpa_job_t data_o
);
  import fpa_pkg::*;

  fpa_job_t            mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_q, rd_q;
  logic [FifoAw:0]     cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (FifoAw + 1)'(push_i) - (FifoAw + 1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

### hdl/fpa_back.sv
module fpa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  input  fpa_pkg::fpa_job_t job_i,
  output logic             pop_o,
  output logic             strobe_o,
  output fpa_pkg::fpa_out_t res_o
);
  import fpa_pkg::*;

  // Restoring divider, one quotient bit per cycle on the doubled operands.
  localparam int unsigned Steps = NumWidth;
  localparam int unsigned CntW = $clog2(Steps + 1);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [NumWidth-1:0] rem_q, num_q;
  logic [NumWidth-1:0] den_q;
  logic [QuoWidth-1:0] quo_q;
  logic              neg_q, fin_q, strobe_q;
  fpa_out_t          res_q;

  assign pop_o = avail_i && !busy_q && !fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; fin_q <= 1'b0; strobe_q <= 1'b0; cnt_q <= '0;
    end else begin
      strobe_q <= 1'b0;
      fin_q <= 1'b0;
      if (pop_o) begin
        if (job_i.is_div && !job_i.div_zero) begin
          busy_q <= 1'b1;
          cnt_q <= CntW'(Steps);
        end else begin
          strobe_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        strobe_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [NumWidth-1:0] trial;
    logic [63:0] qr;
    trial = {rem_q[NumWidth-2:0], num_q[NumWidth-1]};
    if (pop_o) begin
      res_q <= job_i.quick;
      neg_q <= job_i.neg;
      // n2 = 2*|a|<<F + |b|, d2 = 2*|b|
      num_q <= (NumWidth'(job_i.mag_a) << (FracBits + 1)) + NumWidth'(job_i.mag_b);
      den_q <= NumWidth'(job_i.mag_b) << 1;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      if (trial >= den_q) begin
        rem_q <= trial - den_q;
        quo_q <= {quo_q[QuoWidth-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[QuoWidth-2:0], 1'b0};
      end
    end else if (fin_q) begin
      qr = 64'(quo_q);
      if (!neg_q && qr > 64'd2147483647) begin
        res_q.result_value <= 32'h7fff_ffff; res_q.overflow <= 1'b1;
      end else if (neg_q && qr > 64'd2147483648) begin
        res_q.result_value <= 32'h8000_0000; res_q.overflow <= 1'b1;
      end else begin
        res_q.result_value <= neg_q ? 32'(-qr) : qr[31:0];
      end
    end
  end

  assign strobe_o = strobe_q;
  assign res_o = res_q;

endmodule

### hdl/fixed_point_alu.sv
// Each operation passes the front-stage register, the queue and the back-end
// result register; a divide by a nonzero divisor also runs a bit-serial
// restoring divider. Throughput: one transaction per cycle while busy is low;
// a divide holds the back end; busy rises once queue and front stage hold three.
// Reset (rst_ni, asynchronous, active low) empties the pipeline and queue.
// Results are shown for one cycle on done_o; the receiver cannot stall.
module fixed_point_alu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  fpa_pkg::fpa_in_t  req_i,
  output logic             done_o,
  output fpa_pkg::fpa_out_t rsp_o
);
  import fpa_pkg::*;

  logic            take, f_valid, q_empty, q_pop;
  logic [FifoAw:0] q_count;
  fpa_job_t        f_job, q_job;

  assign take = start && !busy;
  // One transaction may still be in the front stage, so leave room for it.
  assign busy = (q_count + (FifoAw + 1)'(f_valid)) >= (FifoAw + 1)'(FifoDepth - 1);

  fpa_front u_front (
    .clk_i, .rst_ni, .take_i(take), .in_i(req_i), .valid_o(f_valid), .job_o(f_job)
  );

  fpa_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .data_i(f_job), .pop_i(q_pop),
    .empty_o(q_empty), .count_o(q_count), .data_o(q_job)
  );

  fpa_back u_back (
    .clk_i, .rst_ni, .avail_i(!q_empty), .job_i(q_job), .pop_o(q_pop),
    .strobe_o(done_o), .res_o(rsp_o)
  );

endmodule

### hdl/fpa_checker.sv
module fpa_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input fpa_pkg::fpa_in_t  req_i,
  input logic             done_o,
  input fpa_pkg::fpa_out_t rsp_o
);
  import fpa_pkg::*;
`include "fixed_point_alu_assert.svh"

  // Checks on each result strobed on done_o, and no done_o after reset.
  `FPA_ASSERT_IMP(a_cmp_flags, clk_i, rst_ni, done_o,
    $countones({rsp_o.greater, rsp_o.less, rsp_o.equal}) <= 1)
  `FPA_ASSERT_IMP(a_dz_zero, clk_i, rst_ni, done_o && rsp_o.divide_by_zero,
    rsp_o.result_value == '0 && !rsp_o.overflow)
  `FPA_ASSERT_IMP(a_cmp_value, clk_i, rst_ni,
    done_o && (rsp_o.greater || rsp_o.less || rsp_o.equal),
    rsp_o.result_value == '0 && !rsp_o.overflow)
  `FPA_ASSERT_NXT(a_no_done_reset, clk_i, rst_ni, !$past(rst_ni), !done_o)

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);
